// ----- design/fsrc_pkg.sv -----
`default_nettype none
package fsrc_pkg;

    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned INSN_W     = 16;
    localparam int unsigned ACC_INSN_W = 24;
    localparam int unsigned EST_W      = 30;
    localparam int unsigned WGT_W      = 32;
    localparam int unsigned ACC_WGT_W  = 48;
    localparam int unsigned CNT_W      = 16;
    localparam int unsigned ID_W       = 16;
    localparam int unsigned SCALE_W    = 7;
    localparam int unsigned REASON_W   = 2;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    typedef logic [REASON_W-1:0] t_reason;

    localparam t_reason REASON_FIXED   = 2'd0;
    localparam t_reason REASON_SECTION = 2'd1;
    localparam t_reason REASON_EOS     = 2'd2;

    typedef enum logic {
        KIND_ASSIGN  = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IR_SCALE  = 1'b1;

    localparam logic [INSN_W-1:0]  MAX_CHUNK_RESET = 16'd1024;
    localparam logic [SCALE_W-1:0] IR_SCALE_RESET  = 7'd4;

    typedef struct packed {
        logic [ADDR_W-1:0]     low;
        logic [ADDR_W-1:0]     high;
        logic [ACC_INSN_W-1:0] insns;
        logic [EST_W-1:0]      est;
        logic [ACC_WGT_W-1:0]  weight;
        logic [CNT_W-1:0]      loops;
        logic                  smc;
        logic [CNT_W-1:0]      indirect;
    } t_summary;

    typedef struct packed {
        logic add;    // fold the current block in
        logic fresh;  // start from an empty region before folding
        logic clear;  // drop the region
    } t_acc_ctl;

endpackage
`default_nettype wire

// ----- design/fsrc_acc.sv -----
`default_nettype none
module fsrc_acc (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire fsrc_pkg::t_acc_ctl                i_ctl,
    input  wire logic [fsrc_pkg::ADDR_W-1:0]       i_start,
    input  wire logic [fsrc_pkg::ADDR_W-1:0]       i_end,
    input  wire logic [fsrc_pkg::INSN_W-1:0]       i_insns,
    input  wire logic [fsrc_pkg::WGT_W-1:0]        i_weight,
    input  wire logic                              i_loop,
    input  wire logic                              i_smc,
    input  wire logic                              i_indirect,
    input  wire logic [fsrc_pkg::SCALE_W-1:0]      i_scale,
    output fsrc_pkg::t_summary                     o_sum
);

    localparam int unsigned PROD_W = fsrc_pkg::ACC_INSN_W + fsrc_pkg::SCALE_W;

    logic [fsrc_pkg::ADDR_W-1:0]     r_low, n_low, b_low;
    logic [fsrc_pkg::ADDR_W-1:0]     r_high, n_high, b_high;
    logic [fsrc_pkg::ACC_INSN_W-1:0] r_insns, n_insns, b_insns;
    logic [fsrc_pkg::ACC_WGT_W-1:0]  r_weight, n_weight, b_weight;
    logic [fsrc_pkg::CNT_W-1:0]      r_loops, n_loops, b_loops;
    logic                            r_smc, n_smc, b_smc;
    logic [fsrc_pkg::CNT_W-1:0]      r_indirect, n_indirect, b_indirect;

    logic [fsrc_pkg::ACC_INSN_W:0]   insn_sum;
    logic [fsrc_pkg::ACC_WGT_W:0]    wgt_sum;
    logic [PROD_W-1:0]               prod;

    always_comb begin
        b_low      = i_ctl.fresh ? '1 : r_low;
        b_high     = i_ctl.fresh ? '0 : r_high;
        b_insns    = i_ctl.fresh ? '0 : r_insns;
        b_weight   = i_ctl.fresh ? '0 : r_weight;
        b_loops    = i_ctl.fresh ? '0 : r_loops;
        b_smc      = i_ctl.fresh ? 1'b0 : r_smc;
        b_indirect = i_ctl.fresh ? '0 : r_indirect;

        insn_sum = {1'b0, b_insns}
                 + {{(fsrc_pkg::ACC_INSN_W + 1 - fsrc_pkg::INSN_W){1'b0}}, i_insns};
        wgt_sum  = {1'b0, b_weight}
                 + {{(fsrc_pkg::ACC_WGT_W + 1 - fsrc_pkg::WGT_W){1'b0}}, i_weight};

        n_low      = r_low;
        n_high     = r_high;
        n_insns    = r_insns;
        n_weight   = r_weight;
        n_loops    = r_loops;
        n_smc      = r_smc;
        n_indirect = r_indirect;

        if (i_ctl.clear) begin
            n_low      = '1;
            n_high     = '0;
            n_insns    = '0;
            n_weight   = '0;
            n_loops    = '0;
            n_smc      = 1'b0;
            n_indirect = '0;
        end else if (i_ctl.add) begin
            n_low      = (i_start < b_low) ? i_start : b_low;
            n_high     = (i_end > b_high) ? i_end : b_high;
            // saturate on carry out
            n_insns    = insn_sum[fsrc_pkg::ACC_INSN_W] ? '1
                                                        : insn_sum[fsrc_pkg::ACC_INSN_W-1:0];
            n_weight   = wgt_sum[fsrc_pkg::ACC_WGT_W] ? '1
                                                      : wgt_sum[fsrc_pkg::ACC_WGT_W-1:0];
            n_loops    = (i_loop && (b_loops != '1)) ? b_loops + 1'b1 : b_loops;
            n_smc      = b_smc | i_smc;
            n_indirect = (i_indirect && (b_indirect != '1)) ? b_indirect + 1'b1
                                                             : b_indirect;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low      <= '1;
            r_high     <= '0;
            r_insns    <= '0;
            r_weight   <= '0;
            r_loops    <= '0;
            r_smc      <= 1'b0;
            r_indirect <= '0;
        end else begin
            r_low      <= n_low;
            r_high     <= n_high;
            r_insns    <= n_insns;
            r_weight   <= n_weight;
            r_loops    <= n_loops;
            r_smc      <= n_smc;
            r_indirect <= n_indirect;
        end
    end

    always_comb begin
        prod           = {{fsrc_pkg::SCALE_W{1'b0}}, r_insns}
                       * {{fsrc_pkg::ACC_INSN_W{1'b0}}, i_scale};
        o_sum.low      = r_low;
        o_sum.high     = r_high;
        o_sum.insns    = r_insns;
        o_sum.est      = (|prod[PROD_W-1:fsrc_pkg::EST_W]) ? '1 : prod[fsrc_pkg::EST_W-1:0];
        o_sum.weight   = r_weight;
        o_sum.loops    = r_loops;
        o_sum.smc      = r_smc;
        o_sum.indirect = r_indirect;
    end

endmodule
`default_nettype wire

// ----- design/fixed_size_region_chunker.sv -----
`default_nettype none
// Region chunker: groups code blocks, given in address order, into regions.
// Input channel (i_in_valid / o_in_ready) takes one block item per cycle while no region closes
// and the output does not stall. Output channel (o_out_valid / i_out_ready) gives one result item
// per cycle while i_out_ready is high: a block assignment, or a summary of a closed region.
// Each block yields 1 to 3 results, in order: summary of the region closed
// before it, its assignment, then the end of stream summary if last_block.
// Configuration channel (i_cfg_valid / o_cfg_ready) is always ready; write it
// only while the block is idle.
// A block waits in the input register; its results then go to the output register.
// A region close or end of stream holds the block in the input register, as the result
// register emits one row per cycle.
// A stall on i_out_ready holds the output register; the input register then
// fills and o_in_ready drops until results move again.
// Reset empties both registers, closes any region, restarts numbering at 0 and
// restores limit 1024 and scale 4.
module fixed_size_region_chunker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,

    input  wire logic                                i_cfg_valid,
    output      logic                                o_cfg_ready,
    input  wire logic [fsrc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [fsrc_pkg::CFG_DATA_W-1:0]     i_cfg_data,

    input  wire logic                                i_in_valid,
    output      logic                                o_in_ready,
    input  wire logic [fsrc_pkg::ADDR_W-1:0]         i_block_start,
    input  wire logic [fsrc_pkg::ADDR_W-1:0]         i_block_end,
    input  wire logic [fsrc_pkg::INSN_W-1:0]         i_block_insns,
    input  wire logic [fsrc_pkg::WGT_W-1:0]          i_block_weight,
    input  wire logic                                i_is_loop_header,
    input  wire logic                                i_is_smc_suspect,
    input  wire logic                                i_is_indirect,
    input  wire logic                                i_last_block,

    output      logic                                o_out_valid,
    input  wire logic                                i_out_ready,
    output      logic                                o_result_kind,
    output      logic [fsrc_pkg::ID_W-1:0]           o_region_id,
    output      logic [fsrc_pkg::REASON_W-1:0]       o_close_reason,
    output      logic [fsrc_pkg::ADDR_W-1:0]         o_region_low_addr,
    output      logic [fsrc_pkg::ADDR_W-1:0]         o_region_high_addr,
    output      logic [fsrc_pkg::ACC_INSN_W-1:0]     o_region_insns,
    output      logic [fsrc_pkg::EST_W-1:0]          o_region_ir_estimate,
    output      logic [fsrc_pkg::ACC_WGT_W-1:0]      o_region_weight,
    output      logic [fsrc_pkg::CNT_W-1:0]          o_region_loops,
    output      logic                                o_region_smc,
    output      logic [fsrc_pkg::CNT_W-1:0]          o_region_indirect,
    output      logic                                o_last_of_run
);

    // configuration
    logic [fsrc_pkg::INSN_W-1:0]  r_max_chunk;
    logic [fsrc_pkg::SCALE_W-1:0] r_ir_scale;

    // input register
    logic                         r_in_valid;
    logic [fsrc_pkg::ADDR_W-1:0]  r_start;
    logic [fsrc_pkg::ADDR_W-1:0]  r_end;
    logic [fsrc_pkg::INSN_W-1:0]  r_insns;
    logic [fsrc_pkg::WGT_W-1:0]   r_weight;
    logic                         r_loop;
    logic                         r_smc;
    logic                         r_indirect;
    logic                         r_last;

    // region control state
    logic                         r_open, n_open;
    logic [fsrc_pkg::ID_W-1:0]    r_num, n_num;
    logic                         r_prev_valid, n_prev_valid;
    logic [fsrc_pkg::ADDR_W-1:0]  r_prev_end, n_prev_end;
    logic                         r_eos, n_eos;

    // output register
    logic                         r_out_valid;
    fsrc_pkg::t_kind              r_kind, n_kind;
    logic [fsrc_pkg::ID_W-1:0]    r_id, n_id;
    fsrc_pkg::t_reason            r_reason, n_reason;
    fsrc_pkg::t_summary           r_sum, n_sum;
    logic                         r_last_of_run, n_last_of_run;

    fsrc_pkg::t_acc_ctl           acc_ctl;
    fsrc_pkg::t_summary           acc_sum;

    logic advance, fire, gap, full, do_close, do_eos, do_assign, consume;

    fsrc_acc u_acc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (acc_ctl),
        .i_start    (r_start),
        .i_end      (r_end),
        .i_insns    (r_insns),
        .i_weight   (r_weight),
        .i_loop     (r_loop),
        .i_smc      (r_smc),
        .i_indirect (r_indirect),
        .i_scale    (r_ir_scale),
        .o_sum      (acc_sum)
    );

    always_comb begin
        advance   = !r_out_valid || i_out_ready;
        fire      = advance && r_in_valid;
        gap       = r_prev_valid && (r_start != r_prev_end);
        full      = acc_sum.insns >= {{(fsrc_pkg::ACC_INSN_W - fsrc_pkg::INSN_W){1'b0}},
                                     r_max_chunk};
        do_eos    = r_eos;
        do_close  = !r_eos && r_open && (gap || full);
        do_assign = !r_eos && !do_close;
        // drop the item once its final result goes out
        consume   = fire && (do_eos || (do_assign && !r_last));

        acc_ctl.add   = fire && do_assign;
        acc_ctl.fresh = !r_open;
        acc_ctl.clear = fire && do_eos;
    end

    assign o_in_ready  = !r_in_valid || consume;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_open        = r_open;
        n_num         = r_num;
        n_prev_valid  = r_prev_valid;
        n_prev_end    = r_prev_end;
        n_eos         = r_eos;
        n_kind        = fsrc_pkg::KIND_SUMMARY;
        n_id          = r_num - 1'b1;
        n_reason      = fsrc_pkg::REASON_EOS;
        n_sum         = acc_sum;
        n_last_of_run = 1'b1;

        if (fire) begin
            if (do_eos) begin
                n_open       = 1'b0;
                n_num        = '0;
                n_prev_valid = 1'b0;
                n_prev_end   = '0;
                n_eos        = 1'b0;
            end else if (do_close) begin
                n_open        = 1'b0;
                n_reason      = gap ? fsrc_pkg::REASON_SECTION : fsrc_pkg::REASON_FIXED;
                n_last_of_run = 1'b0;
            end else begin
                n_open        = 1'b1;
                n_num         = r_open ? r_num : r_num + 1'b1;
                n_prev_valid  = 1'b1;
                n_prev_end    = r_end;
                n_eos         = r_last;
                n_kind        = fsrc_pkg::KIND_ASSIGN;
                n_id          = r_open ? r_num - 1'b1 : r_num;
                n_reason      = fsrc_pkg::REASON_FIXED;
                n_sum         = '0;
                n_last_of_run = !r_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_chunk <= fsrc_pkg::MAX_CHUNK_RESET;
            r_ir_scale  <= fsrc_pkg::IR_SCALE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                fsrc_pkg::CFG_MAX_CHUNK: r_max_chunk <= i_cfg_data;
                fsrc_pkg::CFG_IR_SCALE:  r_ir_scale  <= i_cfg_data[fsrc_pkg::SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_start    <= i_block_start;
            r_end      <= i_block_end;
            r_insns    <= i_block_insns;
            r_weight   <= i_block_weight;
            r_loop     <= i_is_loop_header;
            r_smc      <= i_is_smc_suspect;
            r_indirect <= i_is_indirect;
            r_last     <= i_last_block;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open       <= 1'b0;
            r_num        <= '0;
            r_prev_valid <= 1'b0;
            r_prev_end   <= '0;
            r_eos        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_open       <= n_open;
            r_num        <= n_num;
            r_prev_valid <= n_prev_valid;
            r_prev_end   <= n_prev_end;
            r_eos        <= n_eos;
            if (advance) begin
                r_out_valid <= fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_kind        <= n_kind;
            r_id          <= n_id;
            r_reason      <= n_reason;
            r_sum         <= n_sum;
            r_last_of_run <= n_last_of_run;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_result_kind        = r_kind;
    assign o_region_id          = r_id;
    assign o_close_reason       = r_reason;
    assign o_region_low_addr    = r_sum.low;
    assign o_region_high_addr   = r_sum.high;
    assign o_region_insns       = r_sum.insns;
    assign o_region_ir_estimate = r_sum.est;
    assign o_region_weight      = r_sum.weight;
    assign o_region_loops       = r_sum.loops;
    assign o_region_smc         = r_sum.smc;
    assign o_region_indirect    = r_sum.indirect;
    assign o_last_of_run        = r_last_of_run;

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    typedef struct packed {
        logic [fsrc_pkg::ADDR_W-1:0] start_addr;
        logic [fsrc_pkg::ADDR_W-1:0] end_addr;
        logic [fsrc_pkg::INSN_W-1:0] insns;
        logic [fsrc_pkg::WGT_W-1:0]  weight;
        logic                        loop_hdr;
        logic                        smc;
        logic                        indirect;
        logic                        last;
    } t_block;

    typedef struct packed {
        fsrc_pkg::t_kind                 kind;
        logic [fsrc_pkg::ID_W-1:0]       id;
        fsrc_pkg::t_reason               reason;
        logic [fsrc_pkg::ADDR_W-1:0]     low;
        logic [fsrc_pkg::ADDR_W-1:0]     high;
        logic [fsrc_pkg::ACC_INSN_W-1:0] insns;
        logic [fsrc_pkg::EST_W-1:0]      est;
        logic [fsrc_pkg::ACC_WGT_W-1:0]  weight;
        logic [fsrc_pkg::CNT_W-1:0]      loops;
        logic                            smc;
        logic [fsrc_pkg::CNT_W-1:0]      indirect;
        logic                            last;
    } t_result;

    // one line of the directed table: a block item, or a register setting
    typedef struct {
        bit                              is_cfg;
        logic [fsrc_pkg::CFG_DATA_W-1:0] cfg_limit;
        logic [fsrc_pkg::CFG_DATA_W-1:0] cfg_scale;
        t_block                          blk;
        int                              n;
        logic [fsrc_pkg::ID_W-1:0]       id;
        fsrc_pkg::t_reason               reason;
    } t_row;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned RAND_BLOCKS = 27;

    logic                            i_clk;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [fsrc_pkg::CFG_IDX_W-1:0]  i_cfg_index = fsrc_pkg::CFG_MAX_CHUNK;
    logic [fsrc_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    logic [fsrc_pkg::ADDR_W-1:0]     i_block_start = '0;
    logic [fsrc_pkg::ADDR_W-1:0]     i_block_end = '0;
    logic [fsrc_pkg::INSN_W-1:0]     i_block_insns = '0;
    logic [fsrc_pkg::WGT_W-1:0]      i_block_weight = '0;
    logic                            i_is_loop_header = 1'b0;
    logic                            i_is_smc_suspect = 1'b0;
    logic                            i_is_indirect = 1'b0;
    logic                            i_last_block = 1'b0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    logic                            o_result_kind;
    logic [fsrc_pkg::ID_W-1:0]       o_region_id;
    logic [fsrc_pkg::REASON_W-1:0]   o_close_reason;
    logic [fsrc_pkg::ADDR_W-1:0]     o_region_low_addr;
    logic [fsrc_pkg::ADDR_W-1:0]     o_region_high_addr;
    logic [fsrc_pkg::ACC_INSN_W-1:0] o_region_insns;
    logic [fsrc_pkg::EST_W-1:0]      o_region_ir_estimate;
    logic [fsrc_pkg::ACC_WGT_W-1:0]  o_region_weight;
    logic [fsrc_pkg::CNT_W-1:0]      o_region_loops;
    logic                            o_region_smc;
    logic [fsrc_pkg::CNT_W-1:0]      o_region_indirect;
    logic                            o_last_of_run;

    fixed_size_region_chunker DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_block_start        (i_block_start),
        .i_block_end          (i_block_end),
        .i_block_insns        (i_block_insns),
        .i_block_weight       (i_block_weight),
        .i_is_loop_header     (i_is_loop_header),
        .i_is_smc_suspect     (i_is_smc_suspect),
        .i_is_indirect        (i_is_indirect),
        .i_last_block         (i_last_block),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_result_kind        (o_result_kind),
        .o_region_id          (o_region_id),
        .o_close_reason       (o_close_reason),
        .o_region_low_addr    (o_region_low_addr),
        .o_region_high_addr   (o_region_high_addr),
        .o_region_insns       (o_region_insns),
        .o_region_ir_estimate (o_region_ir_estimate),
        .o_region_weight      (o_region_weight),
        .o_region_loops       (o_region_loops),
        .o_region_smc         (o_region_smc),
        .o_region_indirect    (o_region_indirect),
        .o_last_of_run        (o_last_of_run)
    );

    // chunker state as predicted by the bench
    logic [fsrc_pkg::INSN_W-1:0]     cfg_limit = fsrc_pkg::MAX_CHUNK_RESET;
    logic [fsrc_pkg::SCALE_W-1:0]    cfg_scale = fsrc_pkg::IR_SCALE_RESET;
    logic                            region_is_open = 1'b0;
    logic [fsrc_pkg::ID_W-1:0]       region_counter = '0;
    logic                            prev_end_known = 1'b0;
    logic [fsrc_pkg::ADDR_W-1:0]     prev_end = '0;
    logic [fsrc_pkg::ADDR_W-1:0]     sum_low = '1;
    logic [fsrc_pkg::ADDR_W-1:0]     sum_high = '0;
    logic [fsrc_pkg::ACC_INSN_W-1:0] sum_insns = '0;
    logic [fsrc_pkg::ACC_WGT_W-1:0]  sum_weight = '0;
    logic [fsrc_pkg::CNT_W-1:0]      sum_loops = '0;
    logic                            sum_smc = 1'b0;
    logic [fsrc_pkg::CNT_W-1:0]      sum_indirect = '0;

    t_result                         pending_results[$];
    t_result                         oldest;
    fsrc_pkg::t_reason               first_close;
    logic [fsrc_pkg::ID_W-1:0]       assigned_id;
    logic [fsrc_pkg::ADDR_W-1:0]     stream_addr = '0;
    bit                              idling_on = 1'b1;
    int unsigned                     cycles = 0;
    int                              errors = 0;
    int                              blocks_sent = 0;
    int                              results_seen = 0;
    int                              summaries_seen = 0;
    int                              settings_used = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void clear_region();
        sum_low = '1;
        sum_high = '0;
        sum_insns = '0;
        sum_weight = '0;
        sum_loops = '0;
        sum_smc = 1'b0;
        sum_indirect = '0;
    endfunction

    function automatic t_result region_summary(input fsrc_pkg::t_reason why);
        t_result r;
        logic [63:0] est;
        est = 64'(sum_insns) * 64'(cfg_scale);
        r = '0;
        r.kind = fsrc_pkg::KIND_SUMMARY;
        r.id = region_counter - 1'b1;
        r.reason = why;
        r.low = sum_low;
        r.high = sum_high;
        r.insns = sum_insns;
        r.est = (est > 64'({fsrc_pkg::EST_W{1'b1}})) ? {fsrc_pkg::EST_W{1'b1}}
                                                      : est[fsrc_pkg::EST_W-1:0];
        r.weight = sum_weight;
        r.loops = sum_loops;
        r.smc = sum_smc;
        r.indirect = sum_indirect;
        return r;
    endfunction

    // fold one block into the open region, queue the results it causes
    function automatic int chunk_block(input t_block b);
        t_result res[3];
        int n;
        logic gap;
        logic [63:0] wsum;
        logic [31:0] isum;
        n = 0;
        gap = prev_end_known && (b.start_addr != prev_end);
        first_close = fsrc_pkg::REASON_FIXED;
        if (region_is_open
            && (gap || sum_insns >= fsrc_pkg::ACC_INSN_W'(cfg_limit))) begin
            first_close = gap ? fsrc_pkg::REASON_SECTION : fsrc_pkg::REASON_FIXED;
            res[n] = region_summary(first_close);
            n++;
            region_is_open = 1'b0;
        end
        if (!region_is_open) begin
            clear_region();
            region_counter = region_counter + 1'b1;
            region_is_open = 1'b1;
        end
        if (b.start_addr < sum_low)
            sum_low = b.start_addr;
        if (b.end_addr > sum_high)
            sum_high = b.end_addr;
        isum = 32'(sum_insns) + 32'(b.insns);
        sum_insns = (isum > 32'({fsrc_pkg::ACC_INSN_W{1'b1}})) ? '1
                                                                : isum[fsrc_pkg::ACC_INSN_W-1:0];
        wsum = 64'(sum_weight) + 64'(b.weight);
        sum_weight = (wsum > 64'({fsrc_pkg::ACC_WGT_W{1'b1}})) ? '1
                                                                : wsum[fsrc_pkg::ACC_WGT_W-1:0];
        if (b.loop_hdr && sum_loops != '1)
            sum_loops = sum_loops + 1'b1;
        if (b.smc)
            sum_smc = 1'b1;
        if (b.indirect && sum_indirect != '1)
            sum_indirect = sum_indirect + 1'b1;
        res[n] = '0;
        res[n].kind = fsrc_pkg::KIND_ASSIGN;
        res[n].id = region_counter - 1'b1;
        assigned_id = res[n].id;
        n++;
        prev_end = b.end_addr;
        prev_end_known = 1'b1;
        if (b.last) begin
            if (n == 1)
                first_close = fsrc_pkg::REASON_EOS;
            res[n] = region_summary(fsrc_pkg::REASON_EOS);
            n++;
            region_is_open = 1'b0;
            prev_end_known = 1'b0;
            prev_end = '0;
            region_counter = '0;
            clear_region();
        end
        res[n-1].last = 1'b1;
        for (int k = 0; k < n; k++)
            pending_results.push_back(res[k]);
        return n;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want, got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d results outstanding",
                   cycles, pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result item with nothing pending: kind %0d region %0d",
                       o_result_kind, o_region_id);
                errors++;
            end else begin
                oldest = pending_results.pop_front();
                results_seen++;
                if (oldest.kind == fsrc_pkg::KIND_SUMMARY)
                    summaries_seen++;
                check_field("result_kind", oldest.kind, o_result_kind);
                check_field("region_id", oldest.id, o_region_id);
                check_field("close_reason", oldest.reason, o_close_reason);
                check_field("region_low_addr", oldest.low, o_region_low_addr);
                check_field("region_high_addr", oldest.high, o_region_high_addr);
                check_field("region_insns", oldest.insns, o_region_insns);
                check_field("region_ir_estimate", oldest.est, o_region_ir_estimate);
                check_field("region_weight", oldest.weight, o_region_weight);
                check_field("region_loops", oldest.loops, o_region_loops);
                check_field("region_smc", oldest.smc, o_region_smc);
                check_field("region_indirect", oldest.indirect, o_region_indirect);
                check_field("last_of_run", oldest.last, o_last_of_run);
            end
        end
    end

    // result side: stall in bursts while idling is on
    initial begin
        forever begin
            @(posedge i_clk);
            if (idling_on && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            if (idling_on)
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    end

    task automatic send_block(input t_block b, output int n);
        i_in_valid <= 1'b1;
        i_block_start <= b.start_addr;
        i_block_end <= b.end_addr;
        i_block_insns <= b.insns;
        i_block_weight <= b.weight;
        i_is_loop_header <= b.loop_hdr;
        i_is_smc_suspect <= b.smc;
        i_is_indirect <= b.indirect;
        i_last_block <= b.last;
        do @(posedge i_clk); while (!o_in_ready);
        n = chunk_block(b);
        blocks_sent++;
    endtask

    task automatic hold_sender();
        if (idling_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    // hold input until every pending result item is out
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [fsrc_pkg::CFG_DATA_W-1:0] limit, scale_word);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= fsrc_pkg::CFG_MAX_CHUNK;
        i_cfg_data <= limit;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_limit = limit;
        i_cfg_index <= fsrc_pkg::CFG_IR_SCALE;
        i_cfg_data <= scale_word;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_scale = scale_word[fsrc_pkg::SCALE_W-1:0];
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // flags: {loop header, smc suspect, indirect, last block}
    function automatic t_row blk_row(input logic [31:0] s, e, input logic [15:0] insns,
                                     input logic [31:0] w, input logic [3:0] flags,
                                     input int n, input logic [15:0] id,
                                     input fsrc_pkg::t_reason rsn);
        t_row r;
        r.is_cfg = 1'b0;
        r.cfg_limit = '0;
        r.cfg_scale = '0;
        r.blk = '{s, e, insns, w, flags[3], flags[2], flags[1], flags[0]};
        r.n = n;
        r.id = id;
        r.reason = rsn;
        return r;
    endfunction

    function automatic t_row cfg_row(input logic [15:0] limit, scale_word);
        t_row r;
        r = blk_row('0, '0, '0, '0, 4'b0000, 0, '0, fsrc_pkg::REASON_FIXED);
        r.is_cfg = 1'b1;
        r.cfg_limit = limit;
        r.cfg_scale = scale_word;
        return r;
    endfunction

    // mostly contiguous blocks; some jumps, odd ends, huge counts, stream ends
    function automatic t_block rand_block();
        t_block b;
        b.start_addr = ($urandom_range(0, 7) == 0) ? $urandom() : stream_addr;
        b.end_addr = ($urandom_range(0, 15) == 0) ? $urandom()
                   : b.start_addr + 32'($urandom_range(1, 64) * 4);
        b.insns = ($urandom_range(0, 15) == 0) ? 16'($urandom())
                : 16'($urandom_range(0, 300));
        b.weight = $urandom();
        b.loop_hdr = ($urandom_range(0, 3) == 0);
        b.smc = ($urandom_range(0, 15) == 0);
        b.indirect = ($urandom_range(0, 3) == 0);
        b.last = ($urandom_range(0, 23) == 0);
        stream_addr = b.end_addr;
        return b;
    endfunction

    initial begin
        t_row   dir[$];
        t_row   r;
        t_block b;
        int     n;
        int     k;
        int     ph;

        dir.push_back(blk_row(32'h1000, 32'h1010, 16'd4, 32'd10, 4'b0000, 1, 0,
                              fsrc_pkg::REASON_FIXED));
        dir.push_back(blk_row(32'h1010, 32'h1020, 16'd1020, 32'd20, 4'b1000, 1, 0,
                              fsrc_pkg::REASON_FIXED));
        dir.push_back(blk_row(32'h1020, 32'h1030, 16'd1, 32'd0, 4'b0010, 2, 1,
                              fsrc_pkg::REASON_FIXED));
        dir.push_back(blk_row(32'h2000, 32'h2040, 16'hFFFF, 32'hFFFFFFFF, 4'b1110, 2, 2,
                              fsrc_pkg::REASON_SECTION));
        // jump while over the limit: section end wins
        dir.push_back(blk_row(32'h3000, 32'h3008, 16'd0, 32'd0, 4'b0000, 2, 3,
                              fsrc_pkg::REASON_SECTION));
        dir.push_back(blk_row(32'h3008, 32'h3010, 16'd5, 32'd7, 4'b0001, 2, 3,
                              fsrc_pkg::REASON_EOS));
        // new stream; end below start
        dir.push_back(blk_row(32'hFFFFFFFF, 32'h0, 16'd0, 32'hFFFFFFFF, 4'b1110, 1, 0,
                              fsrc_pkg::REASON_FIXED));
        dir.push_back(blk_row(32'h0, 32'hFFFFFFFF, 16'hFFFF, 32'd0, 4'b0000, 1, 0,
                              fsrc_pkg::REASON_FIXED));
        dir.push_back(blk_row(32'h5000, 32'h5004, 16'd1, 32'd3, 4'b0001, 3, 1,
                              fsrc_pkg::REASON_SECTION));
        // zero limit and zero scale: one block per region
        dir.push_back(cfg_row(16'd0, 16'd0));
        dir.push_back(blk_row(32'h100, 32'h104, 16'd3, 32'd1, 4'b1000, 1, 0,
                              fsrc_pkg::REASON_FIXED));
        dir.push_back(blk_row(32'h104, 32'h108, 16'd0, 32'd2, 4'b0000, 2, 1,
                              fsrc_pkg::REASON_FIXED));
        dir.push_back(blk_row(32'h108, 32'h10C, 16'd0, 32'd4, 4'b0100, 2, 2,
                              fsrc_pkg::REASON_FIXED));
        dir.push_back(blk_row(32'h10C, 32'h110, 16'd7, 32'd8, 4'b0011, 3, 3,
                              fsrc_pkg::REASON_FIXED));
        dir.push_back(cfg_row(16'hFFFF, 16'd127));
        dir.push_back(blk_row(32'h0, 32'h10, 16'hFFFE, 32'hFFFFFFFF, 4'b1110, 1, 0,
                              fsrc_pkg::REASON_FIXED));
        dir.push_back(blk_row(32'h10, 32'h20, 16'hFFFF, 32'hFFFFFFFF, 4'b1010, 1, 0,
                              fsrc_pkg::REASON_FIXED));
        dir.push_back(blk_row(32'h20, 32'h30, 16'd2, 32'd5, 4'b0001, 3, 1,
                              fsrc_pkg::REASON_FIXED));
        dir.push_back(cfg_row(16'd1, 16'd64));
        dir.push_back(blk_row(32'h40, 32'h44, 16'd0, 32'd9, 4'b0000, 1, 0,
                              fsrc_pkg::REASON_FIXED));
        dir.push_back(blk_row(32'h44, 32'h48, 16'd1, 32'd9, 4'b0000, 1, 0,
                              fsrc_pkg::REASON_FIXED));
        dir.push_back(blk_row(32'h48, 32'h4C, 16'd1, 32'd9, 4'b0001, 3, 1,
                              fsrc_pkg::REASON_FIXED));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir[i]) begin
            r = dir[i];
            if (r.is_cfg) begin
                drain();
                set_config(r.cfg_limit, r.cfg_scale);
            end else begin
                hold_sender();
                send_block(r.blk, n);
                if (r.n != 0 && (n != r.n || assigned_id != r.id
                                 || (n > 1 && first_close != r.reason))) begin
                    $error("table line %0d: %0d items, region %0d, reason %0d; %s %0d, %0d, %0d",
                           i, n, assigned_id, first_close, "want", r.n, r.id, r.reason);
                    errors++;
                end
            end
        end
        stream_addr = 32'h4C;

        for (ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0: set_config(16'($urandom_range(1, 64)), 16'd1);
                1: set_config(16'($urandom_range(64, 2048)), 16'($urandom()));
                2: set_config(16'($urandom_range(1, 600)), 16'($urandom_range(0, 127)));
                default: begin
                    idling_on = 1'b0;
                    set_config(fsrc_pkg::MAX_CHUNK_RESET, 16'(fsrc_pkg::IR_SCALE_RESET));
                end
            endcase
            for (k = 0; k < RAND_BLOCKS; k++) begin
                if (ph == 1 && k == 16)
                    drain();
                hold_sender();
                b = rand_block();
                send_block(b, n);
            end
        end

        drain();
        repeat (4) @(posedge i_clk);
        $display("Sent %0d blocks under %0d register settings; checked %0d result items,",
                 blocks_sent, settings_used, results_seen);
        $display("%0d of them region summaries, over gaps, limits and stream ends.",
                 summaries_seen);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
